// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/shcd_pkg.sv -----
package shcd_pkg;

  localparam logic [7:0]  SYNC_BYTE       = 8'h55;
  localparam logic [7:0]  CRC_POLY        = 8'h07;
  localparam logic [15:0] MAX_LEN_RESET   = 16'd2040;
  localparam logic [2:0]  HDR_IDX_LEN_HI  = 3'd0;
  localparam logic [2:0]  HDR_IDX_LEN_LO  = 3'd1;
  localparam logic [2:0]  HDR_IDX_TYPE    = 3'd3;
  localparam logic [2:0]  HDR_IDX_CRC     = 3'd4;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_DEST,
    PH_DCRC
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_type;
    logic [7:0]  dest_addr;
    logic [15:0] data_length;
    logic [7:0]  received_crc;
    logic        last_of_frame;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/sync_header_crc8_deframer.sv -----
// Serial frame deframer: sync byte, five-byte header with CRC-8, payload, destination
// byte, data CRC byte.
// s_axis: one received byte per request in s_axis_tdata.
// cfg: write of max_data_len (cfg_data), always ready; write only while idle.
// m_axis: results. tuser is the kind (payload byte, frame complete, header rejected);
// tlast marks frame completion. Bytes that give no result (hunt, header, destination)
// produce nothing on m_axis.
// Throughput: one byte per cycle, sustained, as long as m_axis drains.
// Each result passes through a two-entry queue and then the output register before it
// is valid on m_axis.
// When m_axis stalls the queue fills and s_axis_tready drops once two results wait
// behind the output register; nothing is lost or repeated.
// Reset (rst, synchronous) empties the queue, returns to sync hunting and loads
// max_data_len with 2040.
`include "assert_macros.svh"

module sync_header_crc8_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // payload_byte, frame_type, dest_addr, data_length,
                                      // received_crc
  output logic [1:0]  m_axis_tuser,   // result_kind
  output logic        m_axis_tlast,   // last_of_frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data        // max_data_len
);

  logic                    accept;
  logic                    push;
  logic                    pop;
  logic [15:0]             max_len;
  shcd_pkg::result_t       res;
  shcd_pkg::result_t       head;
  shcd_pkg::queue_status_t q_status;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !q_status.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= shcd_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len <= cfg_data;
    end
  end

  shcd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (s_axis_tdata),
    .max_len (max_len),
    .push    (push),
    .res     (res)
  );

  shcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  shcd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_status      (q_status),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `ASSERT_IMPLIES(a_no_push_when_full, clk, rst, push, !q_status.full)
  `ASSERT_IMPLIES(a_push_only_on_accept, clk, rst, push, accept)
  `ASSERT_IMPLIES(a_last_matches_kind, clk, rst, m_axis_tvalid,
    m_axis_tlast == (m_axis_tuser == shcd_pkg::KIND_DONE))
  `ASSERT_NEXT(a_pop_fills_output, clk, rst, pop, m_axis_tvalid)

endmodule

// ----- rtl/core/shcd_front.sv -----
module shcd_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  input  logic [15:0]           max_len,
  output logic                  push,
  output shcd_pkg::result_t     res
);

  shcd_pkg::phase_t phase, phase_next;
  logic [2:0]  hdr_cnt;
  logic [7:0]  crc;
  logic [15:0] length;
  logic [7:0]  ftype;
  logic [15:0] pay_cnt;
  logic [7:0]  dest_hold;
  logic [15:0] pay_cnt_inc;
  logic        hdr_bad;

  assign pay_cnt_inc = pay_cnt + 16'd1;
  assign hdr_bad = (crc != rx_byte) || (length > max_len);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      shcd_pkg::PH_HUNT: begin
        if (rx_byte == shcd_pkg::SYNC_BYTE) phase_next = shcd_pkg::PH_HEADER;
      end
      shcd_pkg::PH_HEADER: begin
        if (hdr_cnt == shcd_pkg::HDR_IDX_CRC) begin
          if (hdr_bad) phase_next = shcd_pkg::PH_HUNT;
          else if (length == 16'd0) phase_next = shcd_pkg::PH_DEST;
          else phase_next = shcd_pkg::PH_PAYLOAD;
        end
      end
      shcd_pkg::PH_PAYLOAD: begin
        if (pay_cnt_inc >= length) phase_next = shcd_pkg::PH_DEST;
      end
      shcd_pkg::PH_DEST:  phase_next = shcd_pkg::PH_DCRC;
      shcd_pkg::PH_DCRC:  phase_next = shcd_pkg::PH_HUNT;
      default:            phase_next = shcd_pkg::PH_HUNT;
    endcase
  end

  always_comb begin
    push              = 1'b0;
    res.kind          = shcd_pkg::KIND_PAYLOAD;
    res.payload_byte  = 8'd0;
    res.frame_type    = ftype;
    res.dest_addr     = 8'd0;
    res.data_length   = length;
    res.received_crc  = 8'd0;
    res.last_of_frame = 1'b0;
    unique case (phase)
      shcd_pkg::PH_HEADER: begin
        if (hdr_cnt == shcd_pkg::HDR_IDX_CRC && hdr_bad) begin
          push     = accept;
          res.kind = shcd_pkg::KIND_REJECT;
        end
      end
      shcd_pkg::PH_PAYLOAD: begin
        push             = accept;
        res.payload_byte = rx_byte;
      end
      shcd_pkg::PH_DCRC: begin
        push              = accept;
        res.kind          = shcd_pkg::KIND_DONE;
        res.dest_addr     = dest_hold;
        res.received_crc  = rx_byte;
        res.last_of_frame = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= shcd_pkg::PH_HUNT;
      hdr_cnt   <= 3'd0;
      pay_cnt   <= 16'd0;
      dest_hold <= 8'd0;
    end else if (accept) begin
      phase <= phase_next;
      case (phase)
        shcd_pkg::PH_HUNT: begin
          hdr_cnt <= 3'd0;
        end
        shcd_pkg::PH_HEADER: begin
          hdr_cnt <= (hdr_cnt == shcd_pkg::HDR_IDX_CRC) ? 3'd0 : hdr_cnt + 3'd1;
          if (hdr_cnt == shcd_pkg::HDR_IDX_CRC) pay_cnt <= 16'd0;
        end
        shcd_pkg::PH_PAYLOAD: pay_cnt <= pay_cnt_inc;
        shcd_pkg::PH_DEST:    dest_hold <= rx_byte;
        shcd_pkg::PH_DCRC:    pay_cnt <= 16'd0;
        default: begin
        end
      endcase
    end
  end

  // header payload registers, running CRC over the four bytes ahead of the check byte
  always_ff @(posedge clk) begin
    if (accept && phase == shcd_pkg::PH_HEADER) begin
      case (hdr_cnt)
        shcd_pkg::HDR_IDX_LEN_HI: length[15:8] <= rx_byte;
        shcd_pkg::HDR_IDX_LEN_LO: length[7:0]  <= rx_byte;
        shcd_pkg::HDR_IDX_TYPE:   ftype        <= rx_byte;
        default: begin
        end
      endcase
      if (hdr_cnt == shcd_pkg::HDR_IDX_LEN_HI) crc <= shcd_pkg::crc8_byte(8'd0, rx_byte);
      else if (hdr_cnt != shcd_pkg::HDR_IDX_CRC) crc <= shcd_pkg::crc8_byte(crc, rx_byte);
    end
  end

endmodule

// ----- rtl/core/shcd_queue.sv -----
module shcd_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  shcd_pkg::result_t         push_data,
  input  logic                      pop,
  output shcd_pkg::result_t         head,
  output shcd_pkg::queue_status_t   status
);

  shcd_pkg::result_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head         = entry[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

endmodule

// ----- rtl/core/shcd_back.sv -----
module shcd_back (
  input  logic                      clk,
  input  logic                      rst,
  input  shcd_pkg::result_t         head,
  input  shcd_pkg::queue_status_t   q_status,
  output logic                      pop,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [47:0]               m_axis_tdata,
  output logic [1:0]                m_axis_tuser,
  output logic                      m_axis_tlast
);

  shcd_pkg::result_t out_reg;
  logic              out_valid;

  // refill when the slot is empty or being drained this cycle
  assign pop = !q_status.empty && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_reg <= head;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_reg.received_crc, out_reg.data_length, out_reg.dest_addr,
                          out_reg.frame_type, out_reg.payload_byte};
  assign m_axis_tuser  = out_reg.kind;
  assign m_axis_tlast  = out_reg.last_of_frame;

endmodule

// ----- tb/sv/sync_header_crc8_deframer_chk.sv -----
module sync_header_crc8_deframer_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          bytes_in,
  output int          payload_out,
  output int          frames_done,
  output int          headers_rejected
);

  localparam int HDR_BYTES = 5;

  // shadow of the deframer state
  shcd_pkg::phase_t phase;
  logic [7:0]       hdr [HDR_BYTES];
  logic [2:0]       hdr_cnt;
  logic [15:0]      pay_cnt;
  logic [7:0]       dest_hold;
  logic [15:0]      max_len;

  shcd_pkg::result_t frame_results [$];
  shcd_pkg::result_t exp_res;
  shcd_pkg::result_t act_res;
  shcd_pkg::result_t new_res;
  bit                emitted;

  function automatic logic [7:0] header_crc(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3);
    logic [31:0] bits;
    logic [7:0]  c;
    logic        fb;
    bits = {b0, b1, b2, b3};
    c = 8'h00;
    // bit-serial form, MSB of the first byte first
    for (int i = 31; i >= 0; i--) begin
      fb = c[7] ^ bits[i];
      c  = {c[6:0], 1'b0} ^ (fb ? shcd_pkg::CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic shcd_pkg::result_t make_result(input shcd_pkg::kind_t k,
                                                    input logic [7:0] pay,
                                                    input logic [7:0] dst,
                                                    input logic [7:0] crc);
    shcd_pkg::result_t r;
    r = '0;
    r.kind          = k;
    r.payload_byte  = pay;
    r.frame_type    = hdr[shcd_pkg::HDR_IDX_TYPE];
    r.dest_addr     = dst;
    r.data_length   = {hdr[shcd_pkg::HDR_IDX_LEN_HI], hdr[shcd_pkg::HDR_IDX_LEN_LO]};
    r.received_crc  = crc;
    r.last_of_frame = (k == shcd_pkg::KIND_DONE);
    return r;
  endfunction

  function void deframe_byte(input logic [7:0] b, output bit got,
                             output shcd_pkg::result_t r);
    logic [15:0] len;
    got = 1'b0;
    r   = '0;
    case (phase)
      shcd_pkg::PH_HUNT: begin
        if (b == shcd_pkg::SYNC_BYTE) begin
          phase   = shcd_pkg::PH_HEADER;
          hdr_cnt = '0;
        end
      end
      shcd_pkg::PH_HEADER: begin
        hdr[hdr_cnt] = b;
        hdr_cnt      = hdr_cnt + 3'd1;
        if (hdr_cnt == 3'(HDR_BYTES)) begin
          len     = {hdr[shcd_pkg::HDR_IDX_LEN_HI], hdr[shcd_pkg::HDR_IDX_LEN_LO]};
          hdr_cnt = '0;
          pay_cnt = '0;
          if (header_crc(hdr[0], hdr[1], hdr[2], hdr[3]) != hdr[shcd_pkg::HDR_IDX_CRC] ||
              len > max_len) begin
            phase = shcd_pkg::PH_HUNT;
            got   = 1'b1;
            r     = make_result(shcd_pkg::KIND_REJECT, 8'h00, 8'h00, 8'h00);
          end else begin
            phase = (len == 16'd0) ? shcd_pkg::PH_DEST : shcd_pkg::PH_PAYLOAD;
          end
        end
      end
      shcd_pkg::PH_PAYLOAD: begin
        pay_cnt = pay_cnt + 16'd1;
        if (pay_cnt >= {hdr[shcd_pkg::HDR_IDX_LEN_HI], hdr[shcd_pkg::HDR_IDX_LEN_LO]})
          phase = shcd_pkg::PH_DEST;
        got = 1'b1;
        r   = make_result(shcd_pkg::KIND_PAYLOAD, b, 8'h00, 8'h00);
      end
      shcd_pkg::PH_DEST: begin
        dest_hold = b;
        phase     = shcd_pkg::PH_DCRC;
      end
      shcd_pkg::PH_DCRC: begin
        phase   = shcd_pkg::PH_HUNT;
        pay_cnt = '0;
        got     = 1'b1;
        r       = make_result(shcd_pkg::KIND_DONE, 8'h00, dest_hold, b);
      end
      default: phase = shcd_pkg::PH_HUNT;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      phase     = shcd_pkg::PH_HUNT;
      hdr_cnt   = '0;
      pay_cnt   = '0;
      dest_hold = '0;
      max_len   = shcd_pkg::MAX_LEN_RESET;
      for (int i = 0; i < HDR_BYTES; i++) hdr[i] = '0;
      frame_results.delete();
      mismatches        = 0;
      pending          <= 0;
      bytes_in         <= 0;
      payload_out      <= 0;
      frames_done      <= 0;
      headers_rejected <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        act_res.kind          = shcd_pkg::kind_t'(m_axis_tuser);
        act_res.payload_byte  = m_axis_tdata[7:0];
        act_res.frame_type    = m_axis_tdata[15:8];
        act_res.dest_addr     = m_axis_tdata[23:16];
        act_res.data_length   = m_axis_tdata[39:24];
        act_res.received_crc  = m_axis_tdata[47:40];
        act_res.last_of_frame = m_axis_tlast;
        case (act_res.kind)
          shcd_pkg::KIND_PAYLOAD: payload_out <= payload_out + 1;
          shcd_pkg::KIND_DONE:    frames_done <= frames_done + 1;
          default:                headers_rejected <= headers_rejected + 1;
        endcase
        if (frame_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with nothing pending: kind %0d tdata %h last %b",
                     $realtime, m_axis_tuser, m_axis_tdata, m_axis_tlast);
          mismatches = mismatches + 1;
        end else begin
          exp_res = frame_results.pop_front();
          if (act_res.kind !== exp_res.kind ||
              act_res.payload_byte !== exp_res.payload_byte ||
              act_res.frame_type !== exp_res.frame_type ||
              act_res.dest_addr !== exp_res.dest_addr ||
              act_res.data_length !== exp_res.data_length ||
              act_res.received_crc !== exp_res.received_crc ||
              act_res.last_of_frame !== exp_res.last_of_frame) begin
            if (mismatches < 10) begin
              $display({"%0t: mismatch, exp kind %0d pay %h type %h dest %h",
                        " len %h crc %h last %b"},
                       $realtime, exp_res.kind, exp_res.payload_byte, exp_res.frame_type,
                       exp_res.dest_addr, exp_res.data_length, exp_res.received_crc,
                       exp_res.last_of_frame);
              $display({"%0t:           got kind %0d pay %h type %h dest %h",
                        " len %h crc %h last %b"},
                       $realtime, act_res.kind, act_res.payload_byte, act_res.frame_type,
                       act_res.dest_addr, act_res.data_length, act_res.received_crc,
                       act_res.last_of_frame);
            end
            mismatches = mismatches + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) max_len = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_in <= bytes_in + 1;
        deframe_byte(s_axis_tdata, emitted, new_res);
        if (emitted) frame_results.push_back(new_res);
      end
      pending <= frame_results.size();
    end
  end

endmodule

// ----- tb/sv/sync_header_crc8_deframer_tb.sv -----
module sync_header_crc8_deframer_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF    = 80;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;    // payload_byte, frame_type, dest_addr, data_length,
                                // received_crc
  logic [1:0]  m_axis_tuser;    // result_kind
  logic        m_axis_tlast;    // last_of_frame
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;        // max_data_len

  int          mismatches;
  int          pending;
  int          bytes_in;
  int          payload_out;
  int          frames_done;
  int          headers_rejected;

  bit          steady;
  int          hold_reqs;
  int          frame_bytes;
  int          idle_cycles;
  logic [15:0] cur_max;

  sync_header_crc8_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  sync_header_crc8_deframer_chk chk (
    .clk              (clk),
    .rst              (rst),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .pending          (pending),
    .bytes_in         (bytes_in),
    .payload_out      (payload_out),
    .frames_done      (frames_done),
    .headers_rejected (headers_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // no request moved for too long: the block has hung
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no request for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result sink
  initial begin
    int stall;
    int hold_seen;
    m_axis_tready = 1'b0;
    hold_seen     = 0;
    forever begin
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        repeat (HOLD_OFF) begin
          @(negedge clk);
          m_axis_tready <= 1'b0;
        end
      end
      stall = steady ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk);
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // sync, header (CRC spoilt on request), then payload, destination and data CRC
  // only when the header will be taken
  task automatic send_frame(input logic [15:0] len, input logic [7:0] opt,
                            input logic [7:0] ftype, input logic [7:0] dest,
                            input logic [7:0] dcrc, input bit spoil);
    logic [7:0] hb [4];
    logic [7:0] crc;
    hb[0] = len[15:8];
    hb[1] = len[7:0];
    hb[2] = opt;
    hb[3] = ftype;
    crc   = 8'h00;
    for (int i = 0; i < 4; i++) crc = shcd_pkg::crc8_byte(crc, hb[i]);
    if (spoil) crc = crc ^ 8'($urandom_range(1, 255));
    send_byte(shcd_pkg::SYNC_BYTE);
    for (int i = 0; i < 4; i++) send_byte(hb[i]);
    send_byte(crc);
    frame_bytes += 6;
    if (!spoil && len <= cur_max) begin
      for (int i = 0; i < len; i++)
        send_byte(($urandom_range(0, 7) == 0) ? shcd_pkg::SYNC_BYTE : 8'($urandom));
      send_byte(dest);
      send_byte(dcrc);
      frame_bytes += len + 2;
    end
  endtask

  task automatic wait_idle(input int settle);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_max(input logic [15:0] v);
    wait_idle(4);
    cur_max = v;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_len();
    int top;
    int r;
    if (cur_max == 16'd0) return 16'd0;
    r   = $urandom_range(0, 19);
    top = (cur_max > 200) ? 200 : cur_max;
    if (r == 0) return 16'($urandom_range(0, top));
    if (r == 1 && cur_max <= 200) return cur_max;
    return 16'($urandom_range(0, (cur_max > 16) ? 16 : cur_max));
  endfunction

  task automatic random_phase(input int target);
    int stop;
    int r;
    int nframes;
    stop    = frame_bytes + target;
    nframes = 0;
    while (frame_bytes < stop) begin
      if (nframes % 20 == 0) steady = ($urandom_range(0, 3) == 0);
      nframes++;
      r = $urandom_range(0, 9);
      if (r <= 6) begin
        send_frame(pick_len(), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      end else if (r == 7 || cur_max == 16'hFFFF) begin
        send_frame(pick_len(), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      end else if (r == 8) begin
        send_frame(cur_max + 16'($urandom_range(1, (16'hFFFF - cur_max > 20) ? 20 :
                                                    16'hFFFF - cur_max)),
                   8'($urandom), 8'($urandom), 8'h00, 8'h00, 1'b0);
      end else begin
        // line noise while hunting
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    cfg_valid     = 1'b0;
    cfg_data      = 16'h0000;
    steady        = 1'b0;
    hold_reqs     = 0;
    frame_bytes   = 0;
    cur_max       = shcd_pkg::MAX_LEN_RESET;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, bad CRC, length over the reset maximum
    send_frame(16'd0, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b0);
    send_frame(16'd1, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0);
    send_frame(16'd3, 8'hA5, 8'h5A, 8'h12, 8'h34, 1'b1);
    send_frame(shcd_pkg::MAX_LEN_RESET + 16'd1, 8'h00, 8'h80, 8'h00, 8'h00, 1'b0);
    send_byte(8'h00);
    send_byte(8'hFF);

    write_max(16'd0);
    random_phase(130);
    write_max(16'hFFFF);
    send_frame(16'hFFFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b1);
    // sink holds off while a long frame keeps coming
    hold_reqs   = hold_reqs + 1;
    steady      = 1'b1;
    send_frame(16'd24, 8'h01, 8'h02, 8'h03, 8'h04, 1'b0);
    steady      = 1'b0;
    random_phase(220);
    write_max(16'($urandom_range(1, 300)));
    random_phase(220);
    write_max(16'd16);
    random_phase(170);
    write_max(shcd_pkg::MAX_LEN_RESET);
    random_phase(170);

    wait_idle(12);
    $display("%0d bytes sent over max_data_len 0, 16, 2040, 65535 and a random value;",
             bytes_in);
    $display("%0d payload bytes, %0d frames completed, %0d headers rejected",
             payload_out, frames_done, headers_rejected);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
